// File: src/pll_pkg.sv
// Shared constants, codes and types of the pooled linked-list engine.
package pll_pkg;

	localparam int POOL_NODES = 64;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(POOL_NODES);
	localparam int LINK_W     = ADDR_W + 1;
	localparam int POS_W      = 7;
	localparam int COUNT_W    = 7;
	localparam int STATUS_W   = 2;
	localparam int CMP_W      = (LINK_W > POS_W) ? LINK_W : POS_W;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_NODES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_NODES - 1);

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_FREE_WB,
		S_WALK,
		S_INS_LINK,
		S_INS_PRED,
		S_REM_VIC,
		S_REM_NEXT,
		S_REM_FREE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                  rd_en;
		logic [ADDR_W-1:0]     rd_addr;
		logic                  lk_we;
		logic [ADDR_W-1:0]     lk_addr;
		logic [LINK_W-1:0]     lk_wdata;
		logic                  dt_we;
		logic [ADDR_W-1:0]     dt_addr;
		logic [DATA_WIDTH-1:0] dt_wdata;
	} ram_req_t;

	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic [LINK_W-1:0]   count;
	} res_t;

	// Any link at or above the pool size reads as null.
	function automatic logic [LINK_W-1:0] link_clamp(input logic [LINK_W-1:0] v);
		return (v >= NULL_LINK) ? NULL_LINK : v;
	endfunction

endpackage

// File: src/pooled_linked_list_engine.sv
// Top level of the pooled linked-list engine: stream ports, sequencer, pool, result register.
// Flow: a rejected request goes straight to its result; a request at position 0 works at the
//   head without a walk, and a request at position p >= 1 first walks the list, hopping
//   one link per cycle through the link memory.
// Throughput: one request at a time; s_tready is low until the previous result is passed on.
// Reset: arst_n clears control state; afterwards a pass over every pool entry rebuilds the
//   free chain in the link memory, with s_tready low until it ends.
module pooled_linked_list_engine import pll_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // position[6:0], data_value[38:7], zero pad[39]
	input  logic [0:0]  s_tuser,  // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // status[1:0], element_count[8:2], is_empty[9], zero[15:10]
);

	ram_req_t          ram;
	res_t              res;
	logic [LINK_W-1:0] rd_link;
	logic              slot_free;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_empty_q;

	// the result register frees up when empty or drained this cycle
	assign slot_free = !out_valid_q || m_tready;

	pll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_type   (s_tuser[0]),
		.in_pos    (s_tdata[POS_W-1:0]),
		.in_data   (s_tdata[POS_W +: DATA_WIDTH]),
		.slot_free (slot_free),
		.res       (res),
		.ram       (ram),
		.rd_link   (rd_link)
	);

	pll_node_ram u_ram (
		.clk     (clk),
		.req     (ram),
		.rd_link (rd_link)
	);

	// hold the result word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_status_q <= res.status;
			out_count_q  <= COUNT_W'(res.count);
			out_empty_q  <= (res.count == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_empty_q, out_count_q, out_status_q};

endmodule

// File: src/pll_node_ram.sv
// Node pool storage: next-link memory and data memory, registered read of the link memory.
module pll_node_ram import pll_pkg::*; (
	input  logic              clk,
	input  ram_req_t          req,
	output logic [LINK_W-1:0] rd_link
);

	logic [LINK_W-1:0]     link_mem [POOL_NODES];
	logic [DATA_WIDTH-1:0] data_mem [POOL_NODES];

	always_ff @(posedge clk) begin
		if (req.lk_we) begin
			link_mem[req.lk_addr] <= req.lk_wdata;
		end
		if (req.rd_en) begin
			rd_link <= link_mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.dt_we) begin
			data_mem[req.dt_addr] <= req.dt_wdata;
		end
	end

endmodule

// File: src/pll_ctrl.sv
// Request sequencer: range checks, link walk and read-modify-write of the node pool.
module pll_ctrl import pll_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_type,
	input  logic [POS_W-1:0]      in_pos,
	input  logic [DATA_WIDTH-1:0] in_data,
	input  logic                  slot_free,
	output res_t                  res,
	output ram_req_t              ram,
	input  logic [LINK_W-1:0]     rd_link
);

	state_t                state_q, state_d;
	logic [ADDR_W-1:0]     init_q, init_d;
	logic                  type_q, type_d;
	logic [POS_W-1:0]      pos_q, pos_d;
	logic [DATA_WIDTH-1:0] data_q, data_d;
	logic [LINK_W-1:0]     head_q, head_d;
	logic [LINK_W-1:0]     free_q, free_d;
	logic [LINK_W-1:0]     count_q, count_d;
	logic [LINK_W-1:0]     free_next_q, free_next_d;
	logic [LINK_W-1:0]     cur_q, cur_d;
	logic [LINK_W-1:0]     hops_q, hops_d;
	logic                  pend_q, pend_d;
	logic [LINK_W-1:0]     pred_q, pred_d;
	logic [LINK_W-1:0]     victim_q, victim_d;
	logic [STATUS_W-1:0]   status_q, status_d;

	logic [LINK_W-1:0] rd_clamp;
	logic [LINK_W-1:0] rd_val;
	logic [LINK_W-1:0] cur_sel;
	logic [LINK_W-1:0] victim_sel;
	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  cnt_ext;

	assign rd_clamp   = link_clamp(rd_link);
	assign rd_val     = pend_q ? rd_clamp : NULL_LINK;
	assign cur_sel    = pend_q ? rd_clamp : cur_q;
	assign victim_sel = (pos_q == '0) ? head_q : rd_val;
	assign pos_ext    = CMP_W'(in_pos);
	assign cnt_ext    = CMP_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			head_q  <= NULL_LINK;
			free_q  <= '0;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			init_q  <= init_d;
			head_q  <= head_d;
			free_q  <= free_d;
			count_q <= count_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		type_q      <= type_d;
		pos_q       <= pos_d;
		data_q      <= data_d;
		free_next_q <= free_next_d;
		cur_q       <= cur_d;
		hops_q      <= hops_d;
		pred_q      <= pred_d;
		victim_q    <= victim_d;
		status_q    <= status_d;
	end

	always_comb begin
		state_d     = state_q;
		init_d      = init_q;
		type_d      = type_q;
		pos_d       = pos_q;
		data_d      = data_q;
		head_d      = head_q;
		free_d      = free_q;
		count_d     = count_q;
		free_next_d = free_next_q;
		cur_d       = cur_q;
		hops_d      = hops_q;
		pend_d      = 1'b0;
		pred_d      = pred_q;
		victim_d    = victim_q;
		status_d    = status_q;
		in_ready    = 1'b0;
		res.valid   = 1'b0;
		res.status  = status_q;
		res.count   = count_q;
		ram         = '0;

		case (state_q)
			S_INIT: begin
				// fill the pool free chain: entry i points to i + 1
				ram.lk_we    = 1'b1;
				ram.lk_addr  = init_q;
				ram.lk_wdata = LINK_W'(init_q) + 1'b1;
				ram.dt_we    = 1'b1;
				ram.dt_addr  = init_q;
				ram.dt_wdata = '0;
				init_d       = init_q + 1'b1;
				if (init_q == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					type_d      = in_type;
					pos_d       = in_pos;
					data_d      = in_data;
					cur_d       = head_q;
					hops_d      = LINK_W'(in_pos - 1'b1);
					status_d    = ST_DONE;
					// fetch the free-chain successor right away
					ram.rd_en   = 1'b1;
					ram.rd_addr = free_q[ADDR_W-1:0];
					if (in_type == REQ_INSERT) begin
						if (pos_ext > cnt_ext) begin
							status_d = ST_RANGE;
							state_d  = S_DONE;
						end else if (free_q >= NULL_LINK) begin
							status_d = ST_FULL;
							state_d  = S_DONE;
						end else begin
							state_d = S_FREE_WB;
						end
					end else begin
						if (pos_ext >= cnt_ext) begin
							status_d = ST_RANGE;
							state_d  = S_DONE;
						end else if (in_pos == '0) begin
							state_d = S_REM_VIC;
						end else begin
							state_d = S_WALK;
						end
					end
				end
			end
			S_FREE_WB: begin
				free_next_d  = rd_clamp;
				ram.dt_we    = 1'b1;
				ram.dt_addr  = free_q[ADDR_W-1:0];
				ram.dt_wdata = data_q;
				if (pos_q == '0) begin
					ram.lk_we    = 1'b1;
					ram.lk_addr  = free_q[ADDR_W-1:0];
					ram.lk_wdata = head_q;
					head_d       = free_q;
					free_d       = rd_clamp;
					count_d      = count_q + 1'b1;
					state_d      = S_DONE;
				end else begin
					cur_d   = head_q;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				ram.rd_addr = cur_sel[ADDR_W-1:0];
				ram.rd_en   = (cur_sel != NULL_LINK);
				pend_d      = (cur_sel != NULL_LINK);
				if (hops_q == '0) begin
					pred_d  = cur_sel;
					state_d = (type_q == REQ_INSERT) ? S_INS_LINK : S_REM_VIC;
				end else begin
					cur_d  = cur_sel;
					hops_d = hops_q - 1'b1;
				end
			end
			S_INS_LINK: begin
				ram.lk_we    = 1'b1;
				ram.lk_addr  = free_q[ADDR_W-1:0];
				ram.lk_wdata = rd_val;
				state_d      = S_INS_PRED;
			end
			S_INS_PRED: begin
				ram.lk_we    = (pred_q != NULL_LINK);
				ram.lk_addr  = pred_q[ADDR_W-1:0];
				ram.lk_wdata = free_q;
				free_d       = free_next_q;
				count_d      = count_q + 1'b1;
				state_d      = S_DONE;
			end
			S_REM_VIC: begin
				victim_d    = victim_sel;
				ram.rd_en   = (victim_sel != NULL_LINK);
				ram.rd_addr = victim_sel[ADDR_W-1:0];
				pend_d      = (victim_sel != NULL_LINK);
				state_d     = S_REM_NEXT;
			end
			S_REM_NEXT: begin
				if (pos_q == '0) begin
					head_d = rd_val;
				end else begin
					ram.lk_we    = (pred_q != NULL_LINK);
					ram.lk_addr  = pred_q[ADDR_W-1:0];
					ram.lk_wdata = rd_val;
				end
				state_d = S_REM_FREE;
			end
			S_REM_FREE: begin
				if (victim_q != NULL_LINK) begin
					ram.lk_we    = 1'b1;
					ram.lk_addr  = victim_q[ADDR_W-1:0];
					ram.lk_wdata = free_q;
					free_d       = victim_q;
				end
				count_d = count_q - 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					res.valid = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LINK_W'(POOL_NODES))
		else $error("list count above pool size");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == NULL_LINK))
		else $error("empty list with a live head");

	a_walk_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && hops_q != '0) |=> (hops_q == $past(hops_q) - 1'b1))
		else $error("walk hop counter did not advance");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_PRED) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the list");

endmodule
